>>> hdl/bfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfe_pkg
// Shared types, constants and the sequencer state encoding for the Bloom
// filter engine.
// ---------------------------------------------------------------------------
package bfe_pkg;

  localparam int MaxBits   = 4096;
  localparam int MaxHashes = 16;
  localparam int AddrW     = $clog2(MaxBits);
  localparam int NbW       = 13;
  localparam int NhW       = 5;
  localparam int CfgW      = 13;

  localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime  = 64'h00000100000001B3;
  localparam logic [63:0] SeedOne   = 64'h0000000051ED270B;
  localparam logic [63:0] SeedTwo   = 64'h000000002545F491;
  localparam logic [63:0] MixAdd    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB   = 64'h94D049BB133111EB;
  localparam logic [63:0] HashOneInit = FnvOffset ^ SeedOne;
  localparam logic [63:0] HashTwoInit = FnvOffset ^ SeedTwo;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_NUM_BITS   = 1'b0,
    REG_NUM_HASHES = 1'b1
  } reg_idx_t;

  // Multiplier operand selection for the shared 64x64 unit.
  typedef enum logic [2:0] {
    MUL_FNV1, MUL_FNV2, MUL_MIXA, MUL_MIXB, MUL_PROBE
  } mul_op_t;

  // Request to / response from the shared multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  // Request to / response from the iterative modulo unit.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [NbW-1:0] den;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [AddrW-1:0] rem;
  } mod_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FNV1, S_FNV1_W, S_FNV2, S_FNV2_W,
    S_MIX1_A, S_MIX1_AW, S_MIX1_B, S_MIX1_BW,
    S_MIX2_A, S_MIX2_AW, S_MIX2_B, S_MIX2_BW,
    S_PRB_MUL, S_PRB_MULW, S_PRB_MOD, S_PRB_MODW,
    S_PRB_RD, S_PRB_CHK,
    S_CLR, S_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> hdl/bloom_filter_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte that is not last holds in_stall through two FNV multiplies on the
//   shared 3-step multiplier; a last byte adds the avalanche multiplies, then
//   per probe a multiply, a bit-serial remainder, a store read and a check,
//   and a result state.
// Throughput: one item at a time; in_stall is high while an item is at work
//   and while a result waits. A clear sweeps the whole store, one bit per
//   cycle; reset runs the same clearing pass before the first item is taken.
// ---------------------------------------------------------------------------
// bloom_filter_engine_unit
// Bloom filter with double hashing over a 4096-bit store, driven by a
// sequencer around one shared multiplier and one remainder unit.
// ---------------------------------------------------------------------------
module bloom_filter_engine_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [bfe_pkg::CfgW-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               mode,
  input  wire logic [7:0]               key_byte,
  input  wire logic                     last_byte,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic      [1:0]               done_kind,
  output logic                          present,
  output logic      [12:0]              bits_set,
  output logic      [31:0]              keys_inserted
);
  import bfe_pkg::*;

  state_t state, state_next;

  logic [NbW-1:0] num_bits;
  logic [NhW-1:0] num_hashes;
  logic [63:0]    hash_one;
  logic [63:0]    hash_two;
  logic [63:0]    h1;
  logic [63:0]    h2;
  logic [63:0]    probe_sum;   // h1 + i*h2 + i*i
  logic [NhW-1:0] probe_i;
  logic [NhW-1:0] nh_eff;
  logic [NbW-1:0] nb_eff;
  logic [AddrW-1:0] idx;
  logic [AddrW:0] clr_addr;
  logic [12:0]    set_count;
  logic [31:0]    insert_count;
  logic           all_set;
  logic [1:0]     op_mode;
  logic           op_last;
  logic [7:0]     op_byte;
  logic           op_clear_pending;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  mod_req_t dreq;
  mod_rsp_t drsp;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic             ram_wdata;
  logic             ram_rdata;

  bfe_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  bfe_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  bfe_ram #(.Width(1), .Depth(MaxBits)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    if (num_bits == '0) begin
      nb_eff = NbW'(1);
    end else if (num_bits > NbW'(MaxBits)) begin
      nb_eff = NbW'(MaxBits);
    end else begin
      nb_eff = num_bits;
    end
    if (num_hashes == '0) begin
      nh_eff = NhW'(1);
    end else if (num_hashes > NhW'(MaxHashes)) begin
      nh_eff = NhW'(MaxHashes);
    end else begin
      nh_eff = num_hashes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits   <= NbW'(MaxBits);
      num_hashes <= NhW'(3);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_BITS:   num_bits   <= cfg_data[NbW-1:0];
        REG_NUM_HASHES: num_hashes <= cfg_data[NhW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, unit requests and store port.
  always_comb begin
    state_next = state;
    mreq       = '0;
    dreq       = '0;
    ram_we     = 1'b0;
    ram_addr   = idx;
    ram_wdata  = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          priority case (mode_t'(mode))
            MODE_CLEAR: state_next = S_CLR;
            MODE_NONE:  state_next = S_IDLE;
            default:    state_next = S_FNV1;
          endcase
        end
      end
      S_FNV1: begin
        mreq.start = 1'b1;
        mreq.a = hash_one ^ {56'd0, op_byte};
        mreq.b = FnvPrime;
        state_next = S_FNV1_W;
      end
      S_FNV1_W: if (mrsp.done) state_next = S_FNV2;
      S_FNV2: begin
        mreq.start = 1'b1;
        mreq.a = hash_two ^ {56'd0, op_byte};
        mreq.b = FnvPrime;
        state_next = S_FNV2_W;
      end
      S_FNV2_W: begin
        if (mrsp.done) begin
          state_next = op_last ? S_MIX1_A : S_IDLE;
        end
      end
      S_MIX1_A, S_MIX2_A: begin
        mreq.start = 1'b1;
        mreq.a = h1 ^ (h1 >> 30);
        mreq.b = MixMulA;
        state_next = (state == S_MIX1_A) ? S_MIX1_AW : S_MIX2_AW;
      end
      S_MIX1_AW: if (mrsp.done) state_next = S_MIX1_B;
      S_MIX2_AW: if (mrsp.done) state_next = S_MIX2_B;
      S_MIX1_B, S_MIX2_B: begin
        mreq.start = 1'b1;
        mreq.a = h1 ^ (h1 >> 27);
        mreq.b = MixMulB;
        state_next = (state == S_MIX1_B) ? S_MIX1_BW : S_MIX2_BW;
      end
      S_MIX1_BW: if (mrsp.done) state_next = S_MIX2_A;
      S_MIX2_BW: if (mrsp.done) state_next = S_PRB_MUL;
      S_PRB_MUL: begin
        // i*h2 on the shared multiplier
        mreq.start = 1'b1;
        mreq.a = h2;
        mreq.b = {59'd0, probe_i};
        state_next = S_PRB_MULW;
      end
      S_PRB_MULW: if (mrsp.done) state_next = S_PRB_MOD;
      S_PRB_MOD: begin
        dreq.start = 1'b1;
        dreq.num = probe_sum;
        dreq.den = nb_eff;
        state_next = S_PRB_MODW;
      end
      S_PRB_MODW: if (drsp.done) state_next = S_PRB_RD;
      S_PRB_RD: state_next = S_PRB_CHK;
      S_PRB_CHK: begin
        if (op_mode == MODE_INSERT) begin
          ram_we = 1'b1;
        end
        if (probe_i + NhW'(1) == nh_eff) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_PRB_MUL;
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b0;
        ram_addr  = clr_addr[AddrW-1:0];
        if (clr_addr[AddrW]) begin
          ram_we     = 1'b0;
          state_next = (out_valid && !out_stall) || !out_valid ? S_IDLE : S_CLR;
        end
      end
      S_RESULT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the input while busy or while a finished result waits.
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) begin
      op_mode <= mode;
      op_byte <= key_byte;
      op_last <= last_byte;
    end
    unique case (state)
      S_MIX1_AW, S_MIX2_AW: if (mrsp.done) h1 <= mrsp.p;
      default: ;
    endcase
    // Avalanche staging: h1 holds the word under mixing; h1/h2 swap at the
    // end of each pass so both keys go through the same unit.
    if (state == S_FNV2_W && mrsp.done) begin
      h1 <= hash_one + MixAdd;
      h2 <= mrsp.p + MixAdd;
    end
    if (state == S_MIX1_BW && mrsp.done) begin
      h1 <= h2;
      h2 <= mrsp.p ^ (mrsp.p >> 31);
    end
    if (state == S_MIX2_BW && mrsp.done) begin
      // h2 now holds finished hash one; swap into place
      h1 <= h2;
      h2 <= mrsp.p ^ (mrsp.p >> 31) | 64'd1;
      probe_i <= '0;
      all_set <= 1'b1;
    end
    if (state == S_PRB_MULW && mrsp.done) begin
      probe_sum <= h1 + mrsp.p + 64'(probe_i) * 64'(probe_i);
    end
    if (state == S_PRB_MODW && drsp.done) begin
      idx <= drsp.rem;
    end
    if (state == S_PRB_CHK) begin
      if (!ram_rdata) begin
        all_set <= 1'b0;
      end
      probe_i <= probe_i + NhW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (state == S_IDLE && in_valid && !in_stall &&
                mode_t'(mode) == MODE_CLEAR)) begin
      clr_addr <= '0;
    end else if (state == S_CLR && !clr_addr[AddrW]) begin
      clr_addr <= clr_addr + (AddrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_one     <= HashOneInit;
      hash_two     <= HashTwoInit;
      set_count    <= '0;
      insert_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_valid && !in_stall &&
          mode_t'(mode) == MODE_CLEAR) begin
        hash_one     <= HashOneInit;
        hash_two     <= HashTwoInit;
        set_count    <= '0;
        insert_count <= '0;
        done_kind    <= MODE_CLEAR;
        present      <= 1'b0;
        bits_set     <= '0;
        keys_inserted <= '0;
      end
      // Publish the clear result once the sweep finishes.
      if (state == S_CLR && clr_addr[AddrW] && state_next == S_IDLE &&
          op_clear_pending) begin
        out_valid <= 1'b1;
      end
      if (state == S_FNV1_W && mrsp.done) hash_one <= mrsp.p;
      if (state == S_FNV2_W && mrsp.done) begin
        if (op_last) begin
          hash_one <= HashOneInit;
          hash_two <= HashTwoInit;
        end else begin
          hash_two <= mrsp.p;
        end
      end
      if (state == S_PRB_CHK && op_mode == MODE_INSERT && !ram_rdata) begin
        set_count <= set_count + 13'd1;
      end
      if (state == S_RESULT) begin
        out_valid <= 1'b1;
        done_kind <= op_mode;
        present   <= (op_mode == MODE_QUERY) && all_set;
        bits_set  <= set_count;
        if (op_mode == MODE_INSERT) begin
          keys_inserted <= (insert_count == 32'hFFFFFFFF) ? insert_count
                                                          : insert_count + 32'd1;
          if (insert_count != 32'hFFFFFFFF) begin
            insert_count <= insert_count + 32'd1;
          end
        end else begin
          keys_inserted <= insert_count;
        end
      end
    end
  end

  // A clear item marks its result pending; reset's sweep does not.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_clear_pending <= 1'b0;
    end else if (state == S_IDLE && in_valid && !in_stall &&
                 mode_t'(mode) == MODE_CLEAR) begin
      op_clear_pending <= 1'b1;
    end else if (state == S_CLR && state_next == S_IDLE) begin
      op_clear_pending <= 1'b0;
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted input while busy");
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_kind == MODE_CLEAR) |-> (bits_set == '0 && keys_inserted == '0))
    else $error("clear result not zero");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    set_count <= 13'(MaxBits)) else $error("set count overflow");
  a_present_query: assert property (@(posedge clk) disable iff (rst)
    (out_valid && present) |-> (done_kind == MODE_QUERY))
    else $error("present on non-query");

endmodule

`default_nettype wire

>>> hdl/bfe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfe_ram
// Generic single-port RAM with a registered read.
// ---------------------------------------------------------------------------
module bfe_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hdl/bfe_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfe_mul
// Shared 64x64 low-half multiplier built from three 32x32 partial products,
// one per cycle, accumulated into a registered result.
// ---------------------------------------------------------------------------
module bfe_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bfe_pkg::mul_req_t req,
  output bfe_pkg::mul_rsp_t    rsp
);
  import bfe_pkg::*;

  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [63:0] pp;

  // Step 0: alo*blo, step 1: alo*bhi<<32, step 2: ahi*blo<<32.
  always_comb begin
    unique case (step)
      2'd0:    begin opa = a[31:0];  opb = b[31:0];  end
      2'd1:    begin opa = a[31:0];  opb = b[63:32]; end
      default: begin opa = a[63:32]; opb = b[31:0];  end
    endcase
    pp = 64'(opa) * 64'(opb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= req.a;
      b   <= req.b;
      acc <= '0;
    end else if (busy) begin
      if (step == 2'd0) begin
        acc <= acc + pp;
      end else begin
        acc <= acc + {pp[31:0], 32'd0};
      end
    end
  end

  assign rsp = {done, acc};

endmodule

`default_nettype wire

>>> hdl/bfe_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bfe_mod
// Restoring remainder unit: 64-bit numerator mod a 13-bit divisor, one
// numerator bit per cycle.
// ---------------------------------------------------------------------------
module bfe_mod (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bfe_pkg::mod_req_t req,
  output bfe_pkg::mod_rsp_t    rsp
);
  import bfe_pkg::*;

  logic [63:0]    num;
  logic [NbW-1:0] den;
  logic [NbW-1:0] rem;
  logic [6:0]     cnt;
  logic           busy;
  logic           done;
  logic [NbW:0]   trial;
  logic [NbW:0]   diff;

  always_comb begin
    trial = {rem, num[63]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      // Remainder stays below den, so one compare and subtract per bit.
      if (!diff[NbW]) begin
        rem <= diff[NbW-1:0];
      end else begin
        rem <= trial[NbW-1:0];
      end
    end
  end

  assign rsp = {done, rem[AddrW-1:0]};

endmodule

`default_nettype wire
